/* design/im2col_pkg.sv */
package im2col_pkg;

	// configuration field widths
	localparam int CH_W       = 9;
	localparam int DIM_W      = 12;
	localparam int K_W        = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// result index width
	localparam int IDX_W = 30;

	// output size per axis: up to max dim plus twice max pad
	localparam int OUT_W = 13;
	// signed numerator of the output size
	localparam int NUM_W = 14;
	// signed tap coordinate: out_pos*stride + tap*dil - pad
	localparam int POS_W = 18;

	localparam int PROD_CH_W = CH_W + DIM_W;
	localparam int BASE_W    = PROD_CH_W + DIM_W;
	localparam int RW_W      = 2 * DIM_W;

	// iterative divider, one quotient bit per cycle
	localparam int DIV_STEPS = OUT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_SIZE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_SIZE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DILATION_SIZE = 3'd7;

	// controller to datapath
	typedef struct packed {
		logic clear_pass;
		logic res_zero;
		logic res_bad;
		logic div_start;
		logic div_col;
		logic latch_rows;
		logic start_pass;
		logic stage1;
		logic stage2;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;
		logic pass_active;
		logic div_done;
	} sts_t;

endpackage

/* design/im2col_req_if.sv */
interface im2col_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

/* design/im2col_rsp_if.sv */
interface im2col_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [im2col_pkg::IDX_W-1:0]    source_index;
	logic                            is_padding;
	logic                            is_last;
	logic                            bad_geometry;

	modport source (output valid, output source_index, output is_padding, output is_last,
		output bad_geometry, input ready);
	modport sink (input valid, input source_index, input is_padding, input is_last,
		input bad_geometry, output ready);
endinterface

/* design/im2col_div.sv */
module im2col_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [im2col_pkg::OUT_W-1:0]  dividend,
	input  logic [im2col_pkg::K_W-1:0]    divisor,
	output logic                          done,
	output logic [im2col_pkg::OUT_W-1:0]  quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [im2col_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [im2col_pkg::OUT_W-1:0]     quo_q;
	logic [im2col_pkg::K_W-1:0]       rem_q;
	logic [im2col_pkg::K_W-1:0]       div_q;
	logic [im2col_pkg::K_W:0]         trial;
	logic [im2col_pkg::K_W:0]         rem_next;
	logic                             ge;

	// restoring step: dividend bits leave at the top, quotient bits enter at the bottom
	assign trial    = {rem_q, quo_q[im2col_pkg::OUT_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign rem_next = ge ? (trial - {1'b0, div_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + im2col_pkg::DIV_CNT_W'(1);
			if (cnt_q == im2col_pkg::DIV_CNT_W'(im2col_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[im2col_pkg::OUT_W-2:0], ge};
			rem_q <= rem_next[im2col_pkg::K_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/im2col_dp.sv */
module im2col_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [im2col_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [im2col_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  im2col_pkg::cmd_t                  cmd,
	output im2col_pkg::sts_t                  sts,
	output logic [im2col_pkg::IDX_W-1:0]      source_index,
	output logic                              is_padding,
	output logic                              is_last,
	output logic                              bad_geometry
);

	// configuration
	logic [im2col_pkg::CH_W-1:0]  nch_q;
	logic [im2col_pkg::DIM_W-1:0] img_h_q;
	logic [im2col_pkg::DIM_W-1:0] img_w_q;
	logic [im2col_pkg::K_W-1:0]   ker_h_q;
	logic [im2col_pkg::K_W-1:0]   ker_w_q;
	logic [im2col_pkg::K_W-1:0]   pad_q;
	logic [im2col_pkg::K_W-1:0]   stride_q;
	logic [im2col_pkg::K_W-1:0]   dil_q;

	// pass state
	logic [im2col_pkg::CH_W-1:0]  ch_q;
	logic [im2col_pkg::K_W-1:0]   tr_q;
	logic [im2col_pkg::K_W-1:0]   tc_q;
	logic [im2col_pkg::OUT_W-1:0] orc_q;
	logic [im2col_pkg::OUT_W-1:0] occ_q;
	logic [im2col_pkg::OUT_W-1:0] rows_q;
	logic [im2col_pkg::OUT_W-1:0] cols_q;
	logic                         pass_q;

	// geometry check
	logic [im2col_pkg::K_W-1:0]   kh_m1;
	logic [im2col_pkg::K_W-1:0]   kw_m1;
	logic [2*im2col_pkg::K_W-1:0] ext_h;
	logic [2*im2col_pkg::K_W-1:0] ext_w;
	logic [im2col_pkg::NUM_W-1:0] num_h;
	logic [im2col_pkg::NUM_W-1:0] num_w;
	logic                         bad;

	// divider
	logic [im2col_pkg::OUT_W-1:0] div_dividend;
	logic [im2col_pkg::OUT_W-1:0] div_quotient;
	logic                         div_done;

	// index pipeline
	logic [im2col_pkg::OUT_W+im2col_pkg::K_W-1:0] row_scaled;
	logic [im2col_pkg::OUT_W+im2col_pkg::K_W-1:0] col_scaled;
	logic [2*im2col_pkg::K_W-1:0]                 row_tap;
	logic [2*im2col_pkg::K_W-1:0]                 col_tap;
	logic [im2col_pkg::POS_W-1:0]                 src_row;
	logic [im2col_pkg::POS_W-1:0]                 src_col;
	logic [im2col_pkg::PROD_CH_W-1:0]             pch_s1;
	logic [im2col_pkg::POS_W-1:0]                 sr_s1;
	logic [im2col_pkg::POS_W-1:0]                 sc_s1;
	logic [im2col_pkg::BASE_W-1:0]                base_full;
	logic [im2col_pkg::RW_W-1:0]                  rw_full;
	logic                                         pad_now;
	logic [im2col_pkg::IDX_W-1:0]                 base_s2;
	logic [im2col_pkg::RW_W-1:0]                  rw_s2;
	logic [im2col_pkg::DIM_W-1:0]                 sc_s2;
	logic                                         pad_s2;
	logic [im2col_pkg::IDX_W-1:0]                 idx_sum;

	// counter carries
	logic oc_end, or_end, tc_end, tr_end, ch_end, last_now;

	// results
	logic [im2col_pkg::IDX_W-1:0] res_idx_q;
	logic                         res_pad_q;
	logic                         res_last_q;
	logic                         res_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nch_q    <= im2col_pkg::CH_W'(1);
			img_h_q  <= im2col_pkg::DIM_W'(1);
			img_w_q  <= im2col_pkg::DIM_W'(1);
			ker_h_q  <= im2col_pkg::K_W'(1);
			ker_w_q  <= im2col_pkg::K_W'(1);
			pad_q    <= '0;
			stride_q <= im2col_pkg::K_W'(1);
			dil_q    <= im2col_pkg::K_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				im2col_pkg::REG_NUM_CHANNELS:  nch_q    <= cfg_wdata[im2col_pkg::CH_W-1:0];
				im2col_pkg::REG_IMAGE_HEIGHT:  img_h_q  <= cfg_wdata[im2col_pkg::DIM_W-1:0];
				im2col_pkg::REG_IMAGE_WIDTH:   img_w_q  <= cfg_wdata[im2col_pkg::DIM_W-1:0];
				im2col_pkg::REG_KERNEL_HEIGHT: ker_h_q  <= cfg_wdata[im2col_pkg::K_W-1:0];
				im2col_pkg::REG_KERNEL_WIDTH:  ker_w_q  <= cfg_wdata[im2col_pkg::K_W-1:0];
				im2col_pkg::REG_PAD_SIZE:      pad_q    <= cfg_wdata[im2col_pkg::K_W-1:0];
				im2col_pkg::REG_STRIDE_SIZE:   stride_q <= cfg_wdata[im2col_pkg::K_W-1:0];
				im2col_pkg::REG_DILATION_SIZE: dil_q    <= cfg_wdata[im2col_pkg::K_W-1:0];
				default: ;
			endcase
		end
	end

	// padded extent minus kernel extent, negative means no output
	assign kh_m1 = ker_h_q - im2col_pkg::K_W'(1);
	assign kw_m1 = ker_w_q - im2col_pkg::K_W'(1);
	assign ext_h = dil_q * kh_m1;
	assign ext_w = dil_q * kw_m1;
	assign num_h = im2col_pkg::NUM_W'(img_h_q) + im2col_pkg::NUM_W'({pad_q, 1'b0})
		- im2col_pkg::NUM_W'(ext_h) - im2col_pkg::NUM_W'(1);
	assign num_w = im2col_pkg::NUM_W'(img_w_q) + im2col_pkg::NUM_W'({pad_q, 1'b0})
		- im2col_pkg::NUM_W'(ext_w) - im2col_pkg::NUM_W'(1);

	assign bad = (nch_q == '0) || (ker_h_q == '0) || (ker_w_q == '0) || (stride_q == '0)
		|| num_h[im2col_pkg::NUM_W-1] || num_w[im2col_pkg::NUM_W-1];

	assign div_dividend = cmd.div_col ? num_w[im2col_pkg::OUT_W-1:0]
		: num_h[im2col_pkg::OUT_W-1:0];

	im2col_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (stride_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// stage 1: tap coordinates and channel row product
	assign row_scaled = orc_q * stride_q;
	assign col_scaled = occ_q * stride_q;
	assign row_tap    = tr_q * dil_q;
	assign col_tap    = tc_q * dil_q;
	assign src_row    = im2col_pkg::POS_W'(row_scaled) + im2col_pkg::POS_W'(row_tap)
		- im2col_pkg::POS_W'(pad_q);
	assign src_col    = im2col_pkg::POS_W'(col_scaled) + im2col_pkg::POS_W'(col_tap)
		- im2col_pkg::POS_W'(pad_q);

	always_ff @(posedge clk) begin
		if (cmd.stage1) begin
			pch_s1 <= ch_q * img_h_q;
			sr_s1  <= src_row;
			sc_s1  <= src_col;
		end
	end

	// stage 2: channel base, row offset, bounds check
	assign base_full = pch_s1 * img_w_q;
	assign rw_full   = sr_s1[im2col_pkg::DIM_W-1:0] * img_w_q;
	assign pad_now   = sr_s1[im2col_pkg::POS_W-1] || sc_s1[im2col_pkg::POS_W-1]
		|| (sr_s1 >= im2col_pkg::POS_W'(img_h_q)) || (sc_s1 >= im2col_pkg::POS_W'(img_w_q));

	always_ff @(posedge clk) begin
		if (cmd.stage2) begin
			base_s2 <= base_full[im2col_pkg::IDX_W-1:0];
			rw_s2   <= rw_full;
			sc_s2   <= sc_s1[im2col_pkg::DIM_W-1:0];
			pad_s2  <= pad_now;
		end
	end

	// stage 3: final sum
	assign idx_sum = base_s2 + im2col_pkg::IDX_W'(rw_s2) + im2col_pkg::IDX_W'(sc_s2);

	// nested counter carries, a counter past a shrunk bound wraps on its next advance
	assign oc_end   = (occ_q + (im2col_pkg::OUT_W+1)'(1)) >= (im2col_pkg::OUT_W+1)'(cols_q);
	assign or_end   = (orc_q + (im2col_pkg::OUT_W+1)'(1)) >= (im2col_pkg::OUT_W+1)'(rows_q);
	assign tc_end   = (tc_q + (im2col_pkg::K_W+1)'(1)) >= (im2col_pkg::K_W+1)'(ker_w_q);
	assign tr_end   = (tr_q + (im2col_pkg::K_W+1)'(1)) >= (im2col_pkg::K_W+1)'(ker_h_q);
	assign ch_end   = (ch_q + (im2col_pkg::CH_W+1)'(1)) >= (im2col_pkg::CH_W+1)'(nch_q);
	assign last_now = oc_end && or_end && tc_end && tr_end && ch_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= '0;
			tr_q   <= '0;
			tc_q   <= '0;
			orc_q  <= '0;
			occ_q  <= '0;
			rows_q <= '0;
			cols_q <= '0;
			pass_q <= 1'b0;
		end else begin
			if (cmd.clear_pass) begin
				pass_q <= 1'b0;
			end
			if (cmd.latch_rows) begin
				rows_q <= div_quotient + im2col_pkg::OUT_W'(1);
			end
			if (cmd.start_pass) begin
				cols_q <= div_quotient + im2col_pkg::OUT_W'(1);
				ch_q   <= '0;
				tr_q   <= '0;
				tc_q   <= '0;
				orc_q  <= '0;
				occ_q  <= '0;
				pass_q <= 1'b1;
			end
			if (cmd.emit) begin
				if (!oc_end) begin
					occ_q <= occ_q + im2col_pkg::OUT_W'(1);
				end else begin
					occ_q <= '0;
					if (!or_end) begin
						orc_q <= orc_q + im2col_pkg::OUT_W'(1);
					end else begin
						orc_q <= '0;
						if (!tc_end) begin
							tc_q <= tc_q + im2col_pkg::K_W'(1);
						end else begin
							tc_q <= '0;
							if (!tr_end) begin
								tr_q <= tr_q + im2col_pkg::K_W'(1);
							end else begin
								tr_q <= '0;
								if (!ch_end) begin
									ch_q <= ch_q + im2col_pkg::CH_W'(1);
								end else begin
									ch_q   <= '0;
									pass_q <= 1'b0;
								end
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_zero) begin
			res_idx_q  <= '0;
			res_pad_q  <= 1'b0;
			res_last_q <= 1'b0;
			res_bad_q  <= 1'b0;
		end else if (cmd.res_bad) begin
			res_idx_q  <= '0;
			res_pad_q  <= 1'b0;
			res_last_q <= 1'b0;
			res_bad_q  <= 1'b1;
		end else if (cmd.emit) begin
			res_idx_q  <= pad_s2 ? '0 : idx_sum;
			res_pad_q  <= pad_s2;
			res_last_q <= last_now;
			res_bad_q  <= 1'b0;
		end
	end

	assign sts.bad         = bad;
	assign sts.pass_active = pass_q;
	assign sts.div_done    = div_done;

	assign source_index = res_idx_q;
	assign is_padding   = res_pad_q;
	assign is_last      = res_last_q;
	assign bad_geometry = res_bad_q;

endmodule

/* design/im2col_ctrl.sv */
module im2col_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_restart,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  im2col_pkg::sts_t sts,
	output im2col_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DIV_ROW = 3'd1;
	localparam logic [2:0] S_DIV_COL = 3'd2;
	localparam logic [2:0] S_CALC1   = 3'd3;
	localparam logic [2:0] S_CALC2   = 3'd4;
	localparam logic [2:0] S_CALC3   = 3'd5;
	localparam logic [2:0] S_OUT     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_restart) begin
						cmd.clear_pass = 1'b1;
						if (sts.bad) begin
							cmd.res_bad = 1'b1;
							state_d     = S_OUT;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV_ROW;
						end
					end else if (sts.pass_active) begin
						state_d = S_CALC1;
					end else begin
						cmd.res_zero = 1'b1;
						state_d      = S_OUT;
					end
				end
			end
			S_DIV_ROW: begin
				if (sts.div_done) begin
					cmd.latch_rows = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.div_col    = 1'b1;
					state_d        = S_DIV_COL;
				end
			end
			S_DIV_COL: begin
				if (sts.div_done) begin
					cmd.start_pass = 1'b1;
					state_d        = S_CALC1;
				end
			end
			S_CALC1: begin
				cmd.stage1 = 1'b1;
				state_d    = S_CALC2;
			end
			S_CALC2: begin
				cmd.stage2 = 1'b1;
				state_d    = S_CALC3;
			end
			S_CALC3: begin
				cmd.emit = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/im2col_address_generator.sv */
// channel  | dir | handshake    | payload
// req      | in  | valid/ready  | restart
// rsp      | out | valid/ready  | source_index, is_padding, is_last, bad_geometry
// cfg      | in  | cfg_wr_en    | cfg_index, cfg_wdata
//
// one request at a time: a next-entry request during a pass runs the three index stages, then
// the result and idle states; outside a pass it goes straight to an all-zero result
// a restart request with good geometry adds two output-size divisions on the shared bit-serial
// divider; with bad geometry it goes straight to the bad_geometry result
// reset clears the sequencer, the pass counters and loads the register defaults
// a stalled result holds in the result register; no new request is taken until it leaves
module im2col_address_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	im2col_req_if.sink                        req,
	im2col_rsp_if.source                      rsp,
	input  logic                              cfg_wr_en,
	input  logic [im2col_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [im2col_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// command and status between sequencer and datapath
	im2col_pkg::cmd_t cmd;
	im2col_pkg::sts_t sts;

	// sequencer: request handshake, division waits, index stages, result hold
	im2col_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_restart (req.restart),
		.in_ready   (req.ready),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath: registers, geometry check, divider, nested counters, index pipeline
	im2col_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.source_index (rsp.source_index),
		.is_padding   (rsp.is_padding),
		.is_last      (rsp.is_last),
		.bad_geometry (rsp.bad_geometry)
	);

endmodule

/* design/im2col_chk.sv */
module im2col_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [im2col_pkg::IDX_W-1:0] source_index,
	input logic                         is_padding,
	input logic                         is_last,
	input logic                         bad_geometry
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(source_index)
			&& $stable(is_padding) && $stable(is_last) && $stable(bad_geometry))
		else $error("stalled result changed");

	// padding entries carry index zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_padding |-> source_index == '0)
		else $error("padding entry with nonzero index");

	// bad geometry result carries nothing else
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bad_geometry |-> !is_padding && !is_last && source_index == '0)
		else $error("bad geometry result with other fields set");

	// no request taken while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while result pending");

	// an accepted request leaves the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("block not busy after request");

endmodule

bind im2col_address_generator im2col_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.source_index (rsp.source_index),
	.is_padding   (rsp.is_padding),
	.is_last      (rsp.is_last),
	.bad_geometry (rsp.bad_geometry)
);
